FILE: src/point_in_triangle_test_unit_defines.svh
// Assertion macros for the point-in-triangle test unit.
// Each check is sampled on clk and held off while rst_n is low.
`ifndef POINT_IN_TRIANGLE_TEST_UNIT_DEFINES_SVH
`define POINT_IN_TRIANGLE_TEST_UNIT_DEFINES_SVH

`ifndef SYNTH

`define PIT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`define PIT_ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("assertion failed");

`else

`define PIT_ASSERT_SAME(label, ante, cons)
`define PIT_ASSERT_NEXT(label, ante, cons)
`define PIT_ASSERT_DELAY(label, ante, dly, cons)

`endif

`endif

FILE: src/pit_pkg.sv
package pit_pkg;

  localparam int FIELD_W     = 16;
  localparam int COORD_WIDTH = 16;
  localparam int LIMIT_W     = 64;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int SPLIT_W = DOT_W / 2;
  localparam int HI_W    = DOT_W - SPLIT_W;
  localparam int PPL_W   = SPLIT_W + 1 + DOT_W;
  localparam int PPH_W   = HI_W + DOT_W;
  localparam int WIDE_W  = 2 * DOT_W;
  localparam int NUM_W   = WIDE_W + 1;
  localparam int SUM_W   = NUM_W + 2;
  localparam int CMP_W   = (SUM_W > LIMIT_W + 1) ? SUM_W : LIMIT_W + 1;

  // input register to output strobe, in cycles
  localparam int LATENCY = 7;

  localparam int NPROD = 6;

  typedef struct packed {
    logic [FIELD_W-1:0] point_x;
    logic [FIELD_W-1:0] point_y;
    logic [FIELD_W-1:0] point_z;
    logic [FIELD_W-1:0] vert_a_x;
    logic [FIELD_W-1:0] vert_a_y;
    logic [FIELD_W-1:0] vert_a_z;
    logic [FIELD_W-1:0] vert_b_x;
    logic [FIELD_W-1:0] vert_b_y;
    logic [FIELD_W-1:0] vert_b_z;
    logic [FIELD_W-1:0] vert_c_x;
    logic [FIELD_W-1:0] vert_c_y;
    logic [FIELD_W-1:0] vert_c_z;
  } query_t;

  typedef struct packed {
    logic                    valid;
    logic signed [DOT_W-1:0] d00;
    logic signed [DOT_W-1:0] d01;
    logic signed [DOT_W-1:0] d02;
    logic signed [DOT_W-1:0] d11;
    logic signed [DOT_W-1:0] d12;
  } dot_t;

  typedef struct packed {
    logic                    valid;
    logic signed [NUM_W-1:0] den;
    logic signed [NUM_W-1:0] un;
    logic signed [NUM_W-1:0] vn;
  } num_t;

  function automatic logic signed [COORD_WIDTH-1:0] coord(input logic [FIELD_W-1:0] f);
    return COORD_WIDTH'(signed'(f));
  endfunction

endpackage

FILE: src/pit_diff_dot.sv
module pit_diff_dot (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_accept,
  input  pit_pkg::query_t q,
  output pit_pkg::dot_t  dot
);

  logic signed [pit_pkg::COORD_WIDTH-1:0] cp [3];
  logic signed [pit_pkg::COORD_WIDTH-1:0] ca [3];
  logic signed [pit_pkg::COORD_WIDTH-1:0] cb [3];
  logic signed [pit_pkg::COORD_WIDTH-1:0] cc [3];

  logic signed [pit_pkg::DIFF_W-1:0] v0_nxt [3];
  logic signed [pit_pkg::DIFF_W-1:0] v1_nxt [3];
  logic signed [pit_pkg::DIFF_W-1:0] w_nxt  [3];
  logic signed [pit_pkg::DIFF_W-1:0] v0_r [3];
  logic signed [pit_pkg::DIFF_W-1:0] v1_r [3];
  logic signed [pit_pkg::DIFF_W-1:0] w_r  [3];
  logic                              vld1_r;

  logic signed [pit_pkg::PROD_W-1:0] p00_nxt [3];
  logic signed [pit_pkg::PROD_W-1:0] p01_nxt [3];
  logic signed [pit_pkg::PROD_W-1:0] p02_nxt [3];
  logic signed [pit_pkg::PROD_W-1:0] p11_nxt [3];
  logic signed [pit_pkg::PROD_W-1:0] p12_nxt [3];
  logic signed [pit_pkg::PROD_W-1:0] p00_r [3];
  logic signed [pit_pkg::PROD_W-1:0] p01_r [3];
  logic signed [pit_pkg::PROD_W-1:0] p02_r [3];
  logic signed [pit_pkg::PROD_W-1:0] p11_r [3];
  logic signed [pit_pkg::PROD_W-1:0] p12_r [3];
  logic                              vld2_r;

  pit_pkg::dot_t dot_nxt;
  pit_pkg::dot_t dot_r;

  always_comb begin
    cp[0] = pit_pkg::coord(q.point_x);
    cp[1] = pit_pkg::coord(q.point_y);
    cp[2] = pit_pkg::coord(q.point_z);
    ca[0] = pit_pkg::coord(q.vert_a_x);
    ca[1] = pit_pkg::coord(q.vert_a_y);
    ca[2] = pit_pkg::coord(q.vert_a_z);
    cb[0] = pit_pkg::coord(q.vert_b_x);
    cb[1] = pit_pkg::coord(q.vert_b_y);
    cb[2] = pit_pkg::coord(q.vert_b_z);
    cc[0] = pit_pkg::coord(q.vert_c_x);
    cc[1] = pit_pkg::coord(q.vert_c_y);
    cc[2] = pit_pkg::coord(q.vert_c_z);
    for (int i = 0; i < 3; i++) begin
      v0_nxt[i] = pit_pkg::DIFF_W'(cc[i]) - pit_pkg::DIFF_W'(ca[i]);
      v1_nxt[i] = pit_pkg::DIFF_W'(cb[i]) - pit_pkg::DIFF_W'(ca[i]);
      w_nxt[i]  = pit_pkg::DIFF_W'(cp[i]) - pit_pkg::DIFF_W'(ca[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p00_nxt[i] = v0_r[i] * v0_r[i];
      p01_nxt[i] = v0_r[i] * v1_r[i];
      p02_nxt[i] = v0_r[i] * w_r[i];
      p11_nxt[i] = v1_r[i] * v1_r[i];
      p12_nxt[i] = v1_r[i] * w_r[i];
    end
  end

  always_comb begin
    dot_nxt.valid = vld2_r;
    dot_nxt.d00 = pit_pkg::DOT_W'(p00_r[0]) + pit_pkg::DOT_W'(p00_r[1])
                + pit_pkg::DOT_W'(p00_r[2]);
    dot_nxt.d01 = pit_pkg::DOT_W'(p01_r[0]) + pit_pkg::DOT_W'(p01_r[1])
                + pit_pkg::DOT_W'(p01_r[2]);
    dot_nxt.d02 = pit_pkg::DOT_W'(p02_r[0]) + pit_pkg::DOT_W'(p02_r[1])
                + pit_pkg::DOT_W'(p02_r[2]);
    dot_nxt.d11 = pit_pkg::DOT_W'(p11_r[0]) + pit_pkg::DOT_W'(p11_r[1])
                + pit_pkg::DOT_W'(p11_r[2]);
    dot_nxt.d12 = pit_pkg::DOT_W'(p12_r[0]) + pit_pkg::DOT_W'(p12_r[1])
                + pit_pkg::DOT_W'(p12_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      dot_r.valid <= 1'b0;
    end else begin
      vld1_r      <= in_accept;
      vld2_r      <= vld1_r;
      dot_r.valid <= dot_nxt.valid;
    end
    for (int i = 0; i < 3; i++) begin
      v0_r[i]  <= v0_nxt[i];
      v1_r[i]  <= v1_nxt[i];
      w_r[i]   <= w_nxt[i];
      p00_r[i] <= p00_nxt[i];
      p01_r[i] <= p01_nxt[i];
      p02_r[i] <= p02_nxt[i];
      p11_r[i] <= p11_nxt[i];
      p12_r[i] <= p12_nxt[i];
    end
    dot_r.d00 <= dot_nxt.d00;
    dot_r.d01 <= dot_nxt.d01;
    dot_r.d02 <= dot_nxt.d02;
    dot_r.d11 <= dot_nxt.d11;
    dot_r.d12 <= dot_nxt.d12;
  end

  assign dot = dot_r;

endmodule

FILE: src/pit_cross.sv
module pit_cross (
  input  logic          clk,
  input  logic          rst_n,
  input  pit_pkg::dot_t dot,
  output pit_pkg::num_t num
);

  localparam int NP = pit_pkg::NPROD;

  logic signed [pit_pkg::DOT_W-1:0]  op_a [NP];
  logic signed [pit_pkg::DOT_W-1:0]  op_b [NP];
  logic signed [pit_pkg::PPL_W-1:0]  ppl_nxt [NP];
  logic signed [pit_pkg::PPH_W-1:0]  pph_nxt [NP];
  logic signed [pit_pkg::PPL_W-1:0]  ppl_r [NP];
  logic signed [pit_pkg::PPH_W-1:0]  pph_r [NP];
  logic                              vld4_r;

  logic signed [pit_pkg::WIDE_W-1:0] prod_nxt [NP];
  logic signed [pit_pkg::WIDE_W-1:0] prod_r [NP];
  logic                              vld5_r;

  pit_pkg::num_t num_nxt;
  pit_pkg::num_t num_r;

  // pairs: den = 0 - 1, un = 2 - 3, vn = 4 - 5
  always_comb begin
    op_a[0] = $signed(dot.d00);  op_b[0] = $signed(dot.d11);
    op_a[1] = $signed(dot.d01);  op_b[1] = $signed(dot.d01);
    op_a[2] = $signed(dot.d11);  op_b[2] = $signed(dot.d02);
    op_a[3] = $signed(dot.d01);  op_b[3] = $signed(dot.d12);
    op_a[4] = $signed(dot.d00);  op_b[4] = $signed(dot.d12);
    op_a[5] = $signed(dot.d01);  op_b[5] = $signed(dot.d02);
  end

  // split the first operand: unsigned low half and signed high half
  always_comb begin
    for (int j = 0; j < NP; j++) begin
      ppl_nxt[j] = $signed({1'b0, op_a[j][pit_pkg::SPLIT_W-1:0]}) * op_b[j];
      pph_nxt[j] = $signed(op_a[j][pit_pkg::DOT_W-1:pit_pkg::SPLIT_W]) * op_b[j];
    end
  end

  always_comb begin
    for (int j = 0; j < NP; j++) begin
      prod_nxt[j] = (pit_pkg::WIDE_W'(pph_r[j]) <<< pit_pkg::SPLIT_W)
                  + pit_pkg::WIDE_W'(ppl_r[j]);
    end
  end

  always_comb begin
    num_nxt.valid = vld5_r;
    num_nxt.den = pit_pkg::NUM_W'(prod_r[0]) - pit_pkg::NUM_W'(prod_r[1]);
    num_nxt.un  = pit_pkg::NUM_W'(prod_r[2]) - pit_pkg::NUM_W'(prod_r[3]);
    num_nxt.vn  = pit_pkg::NUM_W'(prod_r[4]) - pit_pkg::NUM_W'(prod_r[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r      <= 1'b0;
      vld5_r      <= 1'b0;
      num_r.valid <= 1'b0;
    end else begin
      vld4_r      <= dot.valid;
      vld5_r      <= vld4_r;
      num_r.valid <= num_nxt.valid;
    end
    for (int j = 0; j < NP; j++) begin
      ppl_r[j]  <= ppl_nxt[j];
      pph_r[j]  <= pph_nxt[j];
      prod_r[j] <= prod_nxt[j];
    end
    num_r.den <= num_nxt.den;
    num_r.un  <= num_nxt.un;
    num_r.vn  <= num_nxt.vn;
  end

  assign num = num_r;

endmodule

FILE: src/pit_decide.sv
module pit_decide (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pit_pkg::num_t                num,
  input  logic [pit_pkg::LIMIT_W-1:0]  limit,
  output logic                         res_valid,
  output logic                         res_inside,
  output logic                         res_degen
);

  logic signed [pit_pkg::NUM_W-1:0] den;
  logic signed [pit_pkg::NUM_W-1:0] un;
  logic signed [pit_pkg::NUM_W-1:0] vn;
  logic signed [pit_pkg::SUM_W-1:0] slack;
  logic                             degen_nxt;
  logic                             inside_nxt;
  logic                             valid_r;
  logic                             inside_r;
  logic                             degen_r;

  always_comb begin
    den   = $signed(num.den);
    un    = $signed(num.un);
    vn    = $signed(num.vn);
    slack = pit_pkg::SUM_W'(den) - pit_pkg::SUM_W'(un) - pit_pkg::SUM_W'(vn);
    // unsigned compare is only meaningful for a non-negative denominator
    degen_nxt = den[pit_pkg::NUM_W-1] ||
                (pit_pkg::CMP_W'($unsigned(den)) < pit_pkg::CMP_W'(limit));
    inside_nxt = !degen_nxt && !un[pit_pkg::NUM_W-1] && !vn[pit_pkg::NUM_W-1]
                 && !slack[pit_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= num.valid;
    end
  end

  always_ff @(posedge clk) begin
    inside_r <= inside_nxt;
    degen_r  <= degen_nxt;
  end

  assign res_valid  = valid_r;
  assign res_inside = inside_r;
  assign res_degen  = degen_r;

endmodule

FILE: src/point_in_triangle_test_unit.sv
// Channel   Handshake              Word
// input     start / busy           in_point_*, in_vert_a_*, in_vert_b_*, in_vert_c_*
// result    out_valid (strobe)     out_inside_res, out_degenerate
// config    cfg_valid / cfg_ready  cfg_data (degenerate limit)
//
// One query enters per cycle; busy stays low, so start alone takes a word.
// Result appears once the taken word has passed every register stage, strobed for one cycle.
// Latency is set by the seven register stages: differences, products, dot sums,
// split partial products, wide products, numerators, decision.
// Synchronous reset clears the valid chain and sets the limit to 1.
// The receiver cannot stall, so the pipeline never holds.
`include "point_in_triangle_test_unit_defines.svh"

module point_in_triangle_test_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_point_x,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_point_y,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_point_z,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_a_x,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_a_y,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_a_z,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_b_x,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_b_y,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_b_z,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_c_x,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_c_y,
  input  logic signed [pit_pkg::FIELD_W-1:0]  in_vert_c_z,
  output logic                                out_valid,
  output logic                                out_inside_res,
  output logic                                out_degenerate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pit_pkg::LIMIT_W-1:0]         cfg_data
);

  pit_pkg::query_t              query;
  pit_pkg::dot_t                dot;
  pit_pkg::num_t                num;
  logic                         in_accept;
  logic [pit_pkg::LIMIT_W-1:0]  limit_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  always_comb begin
    query.point_x  = in_point_x;
    query.point_y  = in_point_y;
    query.point_z  = in_point_z;
    query.vert_a_x = in_vert_a_x;
    query.vert_a_y = in_vert_a_y;
    query.vert_a_z = in_vert_a_z;
    query.vert_b_x = in_vert_b_x;
    query.vert_b_y = in_vert_b_y;
    query.vert_b_z = in_vert_b_z;
    query.vert_c_x = in_vert_c_x;
    query.vert_c_y = in_vert_c_y;
    query.vert_c_z = in_vert_c_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= pit_pkg::LIMIT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  pit_diff_dot u_diff_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .q         (query),
    .dot       (dot)
  );

  pit_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .dot   (dot),
    .num   (num)
  );

  pit_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .num        (num),
    .limit      (limit_r),
    .res_valid  (out_valid),
    .res_inside (out_inside_res),
    .res_degen  (out_degenerate)
  );

  `PIT_ASSERT_SAME(a_degen_outside, out_valid && out_degenerate, !out_inside_res)
  `PIT_ASSERT_DELAY(a_latency_fwd, rst_n && in_accept, pit_pkg::LATENCY, out_valid)
  `PIT_ASSERT_SAME(a_latency_back, out_valid, $past(in_accept, pit_pkg::LATENCY))
  `PIT_ASSERT_NEXT(a_cfg_write, rst_n && cfg_valid && cfg_ready, limit_r == $past(cfg_data))

endmodule
